// ===== rtl/core/ow_pkg.sv =====
// Shared types and constants of the 1-Wire bus master.
package ow_pkg;

  localparam int unsigned BitsPerTransfer = 8;
  localparam int unsigned NumRegs         = 8;
  localparam int unsigned DurW            = 10;
  localparam int unsigned RegIdxW         = $clog2(NumRegs);
  localparam int unsigned BitIdxW         = $clog2(BitsPerTransfer);

  typedef logic [DurW-1:0] ow_dur_t;
  typedef ow_dur_t [NumRegs-1:0] ow_cfg_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_RESET,
    OP_WRITE,
    OP_READ
  } ow_op_e;

  typedef enum logic [1:0] {
    MODE_RELEASE,
    MODE_LOW,
    MODE_HIGH
  } ow_mode_e;

  typedef enum logic [RegIdxW-1:0] {
    REG_RESET_LOW,
    REG_PRESENCE_WAIT,
    REG_RESET_RECOVERY,
    REG_SLOT_LOW,
    REG_READ_SAMPLE,
    REG_READ_RECOVERY,
    REG_WRITE_SLOT,
    REG_WRITE_TAIL
  } ow_reg_e;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_WAIT,
    PH_RST_REC,
    PH_RD_LOW,
    PH_RD_WAIT,
    PH_RD_REC,
    PH_WR_LOW,
    PH_WR_HOLD,
    PH_WR_TAIL
  } ow_phase_e;

  // Register reset values, index order as ow_reg_e
  localparam ow_cfg_t CfgReset = {
    ow_dur_t'(104), ow_dur_t'(104), ow_dur_t'(120), ow_dur_t'(15),
    ow_dur_t'(1),   ow_dur_t'(425), ow_dur_t'(72),  ow_dur_t'(480)
  };

  // Engine status seen by the top level
  typedef struct packed {
    logic       busy;
    logic       done;
    ow_mode_e   drive;
    logic       presence;
    logic [7:0] read_value;
    logic       timer_zero;
  } ow_status_t;

endpackage

// ===== rtl/core/ow_if.sv =====
// Channel interfaces: command tick in, bus status result out.
interface ow_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] write_value;
  logic       line_level;

  modport source (output valid, output opcode, output write_value, output line_level,
                  input ready);
  modport sink   (input valid, input opcode, input write_value, input line_level,
                  output ready);
endinterface

interface ow_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] line_mode;
  logic       busy_res;
  logic       done_res;
  logic       presence_seen;
  logic [7:0] read_value;

  modport source (output valid, output line_mode, output busy_res, output done_res,
                  output presence_seen, output read_value, input ready);
  modport sink   (input valid, input line_mode, input busy_res, input done_res,
                  input presence_seen, input read_value, output ready);
endinterface

// ===== rtl/core/ow_cfg_regs.sv =====
// Timing configuration register file.
module ow_cfg_regs
  import ow_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               we_i,
  input  logic [RegIdxW-1:0] idx_i,
  input  ow_dur_t            data_i,
  output ow_cfg_t            cfg_o
);

  ow_cfg_t regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= CfgReset;
    end else if (we_i) begin
      regs_q[idx_i] <= data_i;
    end
  end

  assign cfg_o = regs_q;

endmodule

// ===== rtl/core/ow_engine.sv =====
// Bus phase sequencer: one tick of protocol state per advance.
module ow_engine
  import ow_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  logic [1:0] opcode_i,
  input  logic [7:0] write_value_i,
  input  logic       line_level_i,
  input  ow_cfg_t    cfg_i,
  output ow_status_t status_o
);

  localparam int unsigned SpanW = (TIMER_BITS > DurW) ? TIMER_BITS : DurW;
  localparam logic [SpanW-1:0] TMax = SpanW'((64'd1 << TIMER_BITS) - 64'd1);

  typedef logic [TIMER_BITS-1:0] timer_t;

  // Zero counts as one tick; long values clip to the timer range
  function automatic timer_t span(input ow_dur_t v);
    logic [SpanW-1:0] ve;
    ve = SpanW'(v);
    if (v == '0) return timer_t'(1);
    if (ve > TMax) return timer_t'(TMax);
    return timer_t'(ve);
  endfunction

  ow_phase_e            phase_q, phase_d;
  timer_t               time_q, time_d;
  logic [BitIdxW-1:0]   bit_q, bit_d;
  logic [7:0]           shift_q, shift_d;
  logic                 pres_q, pres_d;
  ow_mode_e             drive_q, drive_d;
  logic [7:0]           rd_q, rd_d;
  logic                 done_q, done_d;

  logic    last;
  logic    expire;
  logic    load;
  ow_reg_e sel;
  ow_op_e  op;

  assign last   = (bit_q == BitIdxW'(BitsPerTransfer - 1));
  assign expire = (phase_q != PH_IDLE) && (time_q <= timer_t'(1));
  assign op     = ow_op_e'(opcode_i);

  // Next state
  always_comb begin
    phase_d = phase_q;
    time_d  = time_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    pres_d  = pres_q;
    drive_d = drive_q;
    rd_d    = rd_q;
    load    = 1'b0;
    sel     = REG_SLOT_LOW;
    if (phase_q == PH_IDLE) begin
      case (op)
        OP_RESET: begin
          phase_d = PH_RST_LOW; sel = REG_RESET_LOW; load = 1'b1; drive_d = MODE_LOW;
        end
        OP_WRITE: begin
          shift_d = write_value_i; bit_d = '0;
          phase_d = PH_WR_LOW; load = 1'b1; drive_d = MODE_LOW;
        end
        OP_READ: begin
          bit_d = '0;
          phase_d = PH_RD_LOW; load = 1'b1; drive_d = MODE_LOW;
        end
        default: ;
      endcase
    end else if (!expire) begin
      time_d = time_q - timer_t'(1);
    end else begin
      case (phase_q)
        PH_RST_LOW: begin
          phase_d = PH_RST_WAIT; sel = REG_PRESENCE_WAIT; load = 1'b1;
          drive_d = MODE_RELEASE;
        end
        PH_RST_WAIT: begin
          pres_d  = ~line_level_i;
          phase_d = PH_RST_REC; sel = REG_RESET_RECOVERY; load = 1'b1;
          drive_d = MODE_RELEASE;
        end
        PH_RD_LOW: begin
          phase_d = PH_RD_WAIT; sel = REG_READ_SAMPLE; load = 1'b1;
          drive_d = MODE_RELEASE;
        end
        PH_RD_WAIT: begin
          shift_d = {line_level_i, shift_q[7:1]};
          phase_d = PH_RD_REC; sel = REG_READ_RECOVERY; load = 1'b1;
          drive_d = MODE_RELEASE;
        end
        PH_RD_REC: begin
          if (last) begin
            rd_d = shift_q; phase_d = PH_IDLE; time_d = '0;
          end else begin
            bit_d = bit_q + BitIdxW'(1);
            phase_d = PH_RD_LOW; load = 1'b1; drive_d = MODE_LOW;
          end
        end
        PH_WR_LOW: begin
          shift_d = {1'b0, shift_q[7:1]};
          phase_d = PH_WR_HOLD; sel = REG_WRITE_SLOT; load = 1'b1;
          drive_d = shift_q[0] ? MODE_HIGH : MODE_LOW;
        end
        PH_WR_HOLD: begin
          if (!last) begin
            bit_d = bit_q + BitIdxW'(1);
            phase_d = PH_WR_LOW; load = 1'b1; drive_d = MODE_LOW;
          end else if (cfg_i[REG_WRITE_TAIL] == '0) begin
            drive_d = MODE_HIGH; phase_d = PH_IDLE; time_d = '0;
          end else begin
            phase_d = PH_WR_TAIL; sel = REG_WRITE_TAIL; load = 1'b1;
            drive_d = MODE_HIGH;
          end
        end
        default: begin
          // reset recovery, write tail, stray codes
          phase_d = PH_IDLE; time_d = '0;
        end
      endcase
    end
    if (load) time_d = span(cfg_i[sel]);
  end

  // Outputs: done flag of this tick
  always_comb begin
    done_d = 1'b0;
    if (expire) begin
      case (phase_q)
        PH_RST_LOW, PH_RST_WAIT, PH_RD_LOW, PH_RD_WAIT, PH_WR_LOW: done_d = 1'b0;
        PH_RD_REC:  done_d = last;
        PH_WR_HOLD: done_d = last && (cfg_i[REG_WRITE_TAIL] == '0);
        default:    done_d = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      time_q  <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      pres_q  <= 1'b0;
      drive_q <= MODE_RELEASE;
      rd_q    <= '0;
      done_q  <= 1'b0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      time_q  <= time_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      pres_q  <= pres_d;
      drive_q <= drive_d;
      rd_q    <= rd_d;
      done_q  <= done_d;
    end
  end

  assign status_o.busy       = (phase_q != PH_IDLE);
  assign status_o.done       = done_q;
  assign status_o.drive      = drive_q;
  assign status_o.presence   = pres_q;
  assign status_o.read_value = rd_q;
  assign status_o.timer_zero = (time_q == '0);

endmodule

// ===== rtl/core/one_wire_bus_master.sv =====
// Top level of the 1-Wire bus master: tick register, sequencer, result register.
//
//  channel  dir  transaction                      payload
//  item_i   in   one microsecond tick             opcode, write_value, line_level
//  res_o    out  bus status after that tick       line_mode, busy_res, done_res,
//                                                 presence_seen, read_value
//  cfg_*    in   timing register write            cfg_idx_i, cfg_data_i
//
// One tick per clock sustained while res_o does not stall; a taken tick passes
// through the tick register, then the sequencer state that is the result.
// The sequencer state register doubles as the result register, so a tick
// moves on only when the result slot is empty or being drained.
// Reset: sequencer idle, bus released, timing registers at their defaults.
// Stalls on res_o back up through the tick register to item_i.ready.
module one_wire_bus_master
  import ow_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  ow_in_if.sink              item_i,
  ow_out_if.source           res_o,
  input  logic               cfg_we_i,
  input  logic [RegIdxW-1:0] cfg_idx_i,
  input  ow_dur_t            cfg_data_i
);

  ow_cfg_t    cfg;
  ow_status_t status;

  // tick register
  logic       tick_valid_q;
  logic [1:0] op_q;
  logic [7:0] wv_q;
  logic       lv_q;
  logic       out_valid_q;
  logic       adv;

  // tick enters the sequencer when the result slot is free or draining
  assign adv          = tick_valid_q && (!out_valid_q || res_o.ready);
  assign item_i.ready = !tick_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      tick_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      op_q <= item_i.opcode;
      wv_q <= item_i.write_value;
      lv_q <= item_i.line_level;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  ow_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  ow_engine #(
    .TIMER_BITS (TIMER_BITS)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .opcode_i      (op_q),
    .write_value_i (wv_q),
    .line_level_i  (lv_q),
    .cfg_i         (cfg),
    .status_o      (status)
  );

  assign res_o.valid         = out_valid_q;
  assign res_o.line_mode     = status.drive;
  assign res_o.busy_res      = status.busy;
  assign res_o.done_res      = status.done;
  assign res_o.presence_seen = status.presence;
  assign res_o.read_value    = status.read_value;

`ifndef SYNTHESIS
  // timer runs exactly while a command is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.busy != status.timer_zero)
    else $error("timer and busy disagree");

  // a finishing tick always lands in idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.done |-> !status.busy)
    else $error("done while busy");

  // a held tick is not dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_valid_q && !adv) |=> tick_valid_q)
    else $error("tick lost");

  // sequencer state only moves with a tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(status))
    else $error("state changed without a tick");
`endif

endmodule

// ===== tb/tb_one_wire_bus_master.sv =====
// Self-checking testbench of the 1-Wire bus master: directed and random ticks against a tick-level bus model.
module tb_one_wire_bus_master;
  import ow_pkg::*;

  // Line level pattern fed to a command's ticks
  localparam int LvLow  = 0;
  localparam int LvHigh = 1;
  localparam int LvRand = 2;

  localparam int unsigned StallLimit  = 2000;  // watchdog, cycles without a transaction
  localparam int unsigned HoldOffLen  = 300;   // one long receiver hold-off
  localparam int unsigned HoldOffAt   = 500;   // ... after this many checked results
  localparam int unsigned RandomTicks = 400;

  typedef struct packed {
    ow_op_e     op;
    logic [7:0] wv;
    logic       lv;
  } bus_tick_t;

  typedef struct packed {
    ow_mode_e   mode;
    logic       busy;
    logic       done;
    logic       presence;
    logic [7:0] rd;
  } bus_status_t;

  logic    clk_i = 1'b0;
  logic    rst_ni;
  logic    cfg_we;
  logic [RegIdxW-1:0] cfg_idx;
  ow_dur_t cfg_data;

  ow_in_if  item_if ();
  ow_out_if res_if ();

  one_wire_bus_master u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item_if),
    .res_o     (res_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Stimulus and expectations
  bus_tick_t   tick_q[$];
  bus_status_t status_q[$];
  bus_status_t head_s;

  // Bus model state and its copy of the timing registers
  ow_dur_t     timing [NumRegs];
  ow_phase_e   m_phase;
  int unsigned m_left;
  logic [2:0]  m_bit;
  logic [7:0]  m_shift;
  logic [7:0]  m_last_rd;
  logic        m_presence;
  ow_mode_e    m_mode;

  int unsigned n_cmd [4];
  int unsigned n_presence;
  int unsigned n_done;
  int unsigned checked;
  int unsigned errors;
  int unsigned busy_ticks;
  int unsigned hold_left;
  int unsigned stuck;
  bit          hold_done;
  bit          quiet;  // no idling on either side while set

  // A zero register still makes a one-tick phase
  function automatic int unsigned dur_of(input ow_reg_e r);
    return (timing[r] == '0) ? 1 : int'(timing[r]);
  endfunction

  // Ticks from command acceptance up to and including the done tick
  function automatic int unsigned command_ticks(input ow_op_e op);
    int unsigned tail;
    tail = (timing[REG_WRITE_TAIL] == '0) ? 0 : dur_of(REG_WRITE_TAIL);
    case (op)
      OP_RESET: return dur_of(REG_RESET_LOW) + dur_of(REG_PRESENCE_WAIT)
                       + dur_of(REG_RESET_RECOVERY) + 1;
      OP_WRITE: return BitsPerTransfer * (dur_of(REG_SLOT_LOW) + dur_of(REG_WRITE_SLOT))
                       + tail + 1;
      OP_READ:  return BitsPerTransfer * (dur_of(REG_SLOT_LOW) + dur_of(REG_READ_SAMPLE)
                       + dur_of(REG_READ_RECOVERY)) + 1;
      default:  return 1;
    endcase
  endfunction

  task automatic enter_phase(input ow_phase_e ph, input ow_reg_e r, input ow_mode_e md);
    m_phase = ph;
    m_left  = dur_of(r);
    m_mode  = md;
  endtask

  task automatic end_command();
    m_phase = PH_IDLE;
    m_left  = 0;
    n_done++;
  endtask

  // One tick through the bus model; queues the status it leaves behind
  task automatic advance_bus(input logic [1:0] op_bits, input logic [7:0] wv, input logic lv);
    bus_status_t s;
    logic        done;
    logic        last;
    done = 1'b0;
    last = (m_bit == 3'(BitsPerTransfer - 1));
    if (m_phase == PH_IDLE) begin
      n_cmd[op_bits]++;
      case (ow_op_e'(op_bits))
        OP_RESET: enter_phase(PH_RST_LOW, REG_RESET_LOW, MODE_LOW);
        OP_WRITE: begin
          m_shift = wv;
          m_bit   = '0;
          enter_phase(PH_WR_LOW, REG_SLOT_LOW, MODE_LOW);
        end
        OP_READ: begin
          m_bit = '0;
          enter_phase(PH_RD_LOW, REG_SLOT_LOW, MODE_LOW);
        end
        default: ;
      endcase
    end else if (m_left > 1) begin
      m_left--;
    end else begin
      case (m_phase)
        PH_RST_LOW: enter_phase(PH_RST_WAIT, REG_PRESENCE_WAIT, MODE_RELEASE);
        PH_RST_WAIT: begin
          // presence is active low
          m_presence = ~lv;
          if (!lv) n_presence++;
          enter_phase(PH_RST_REC, REG_RESET_RECOVERY, MODE_RELEASE);
        end
        PH_RD_LOW: enter_phase(PH_RD_WAIT, REG_READ_SAMPLE, MODE_RELEASE);
        PH_RD_WAIT: begin
          m_shift = {lv, m_shift[7:1]};
          enter_phase(PH_RD_REC, REG_READ_RECOVERY, MODE_RELEASE);
        end
        PH_RD_REC: begin
          if (last) begin
            m_last_rd = m_shift;
            end_command();
            done = 1'b1;
          end else begin
            m_bit++;
            enter_phase(PH_RD_LOW, REG_SLOT_LOW, MODE_LOW);
          end
        end
        PH_WR_LOW: begin
          // one bits are actively driven high
          if (m_shift[0]) enter_phase(PH_WR_HOLD, REG_WRITE_SLOT, MODE_HIGH);
          else enter_phase(PH_WR_HOLD, REG_WRITE_SLOT, MODE_LOW);
          m_shift = m_shift >> 1;
        end
        PH_WR_HOLD: begin
          if (!last) begin
            m_bit++;
            enter_phase(PH_WR_LOW, REG_SLOT_LOW, MODE_LOW);
          end else if (timing[REG_WRITE_TAIL] == '0) begin
            // no tail: done on the tick the last slot ends
            m_mode = MODE_HIGH;
            end_command();
            done = 1'b1;
          end else begin
            enter_phase(PH_WR_TAIL, REG_WRITE_TAIL, MODE_HIGH);
          end
        end
        default: begin
          end_command();
          done = 1'b1;
        end
      endcase
    end
    s.mode     = m_mode;
    s.busy     = (m_phase != PH_IDLE);
    s.done     = done;
    s.presence = m_presence;
    s.rd       = m_last_rd;
    status_q.push_back(s);
  endtask

  task automatic check_field(input string name, input int unsigned exp_v, input int unsigned got);
    if (exp_v != got) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, exp_v, got);
    end
  endtask

  // Driver: offers queued ticks, predicts each one as it is taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (item_if.valid && item_if.ready)
        advance_bus(item_if.opcode, item_if.write_value, item_if.line_level);
      if (!item_if.valid || item_if.ready) begin
        if (tick_q.size() != 0 && (quiet || $urandom_range(99) >= 6)) begin
          item_if.valid       <= 1'b1;
          item_if.opcode      <= tick_q[0].op;
          item_if.write_value <= tick_q[0].wv;
          item_if.line_level  <= tick_q[0].lv;
          void'(tick_q.pop_front());
        end else begin
          item_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (status_q.size() == 0) begin
          errors++;
          $error("result transaction with no tick outstanding");
        end else begin
          head_s = status_q.pop_front();
          checked++;
          check_field("line_mode", head_s.mode, res_if.line_mode);
          check_field("busy_res", head_s.busy, res_if.busy_res);
          check_field("done_res", head_s.done, res_if.done_res);
          check_field("presence_seen", head_s.presence, res_if.presence_seen);
          check_field("read_value", head_s.rd, res_if.read_value);
        end
      end
      // one long hold-off so the tick register backs up to the input
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (!hold_done && checked >= HoldOffAt) begin
        hold_done = 1'b1;
        hold_left = HoldOffLen;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= quiet || ($urandom_range(99) >= 6);
      end
    end
  end

  // Watchdog: ends the run when work is pending and nothing moves
  always @(posedge clk_i) begin
    if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready)) begin
      stuck = 0;
    end else if (tick_q.size() != 0 || status_q.size() != 0 || item_if.valid) begin
      stuck++;
      if (stuck >= StallLimit) begin
        $display("stalled after %0d ticks checked, %0d ticks still queued",
                 checked, tick_q.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  // Push one command and enough ticks to cover it, then a short idle gap
  task automatic queue_command(input ow_op_e op, input logic [7:0] wv, input int lv_sel);
    int unsigned n;
    bus_tick_t   t;
    n = command_ticks(op);
    for (int unsigned i = 0; i < n; i++) begin
      if (i == 0) begin
        t.op = op;
        t.wv = wv;
      end else begin
        // commands while busy must be ignored, done tick included
        t.op = ow_op_e'($urandom_range(0, 3));
        t.wv = 8'($urandom());
      end
      case (lv_sel)
        LvLow:   t.lv = 1'b0;
        LvHigh:  t.lv = 1'b1;
        default: t.lv = 1'($urandom());
      endcase
      tick_q.push_back(t);
    end
    busy_ticks += n;
    repeat ($urandom_range(0, 2)) tick_q.push_back('{OP_NONE, 8'($urandom()), 1'($urandom())});
  endtask

  task automatic fill_timing(input ow_dur_t v);
    for (int i = 0; i < NumRegs; i++) timing[i] = v;
  endtask

  // Only called while the block is idle with nothing outstanding
  task automatic program_timing();
    for (int i = 0; i < NumRegs; i++) begin
      @(posedge clk_i);
      cfg_we   <= 1'b1;
      cfg_idx  <= ow_reg_e'(i);
      cfg_data <= timing[i];
    end
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic random_timing();
    for (int i = 0; i < NumRegs; i++) begin
      case ($urandom_range(0, 9))
        0:       timing[i] = '0;
        1, 2:    timing[i] = ow_dur_t'($urandom_range(5, 12));
        default: timing[i] = ow_dur_t'($urandom_range(1, 4));
      endcase
    end
    program_timing();
  endtask

  // Wait until every tick is checked and the model is back in idle
  task automatic drain();
    forever begin
      while (tick_q.size() != 0 || status_q.size() != 0 || item_if.valid) @(negedge clk_i);
      if (m_phase == PH_IDLE) break;
      tick_q.push_back('{OP_NONE, 8'h00, 1'b1});
    end
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    rst_ni              = 1'b0;
    item_if.valid       = 1'b0;
    item_if.opcode      = OP_NONE;
    item_if.write_value = '0;
    item_if.line_level  = 1'b1;
    res_if.ready        = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = REG_RESET_LOW;
    cfg_data            = '0;
    for (int i = 0; i < NumRegs; i++) timing[i] = CfgReset[i];
    m_phase    = PH_IDLE;
    m_left     = 0;
    m_bit      = '0;
    m_shift    = '0;
    m_last_rd  = '0;
    m_presence = 1'b0;
    m_mode     = MODE_RELEASE;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset timing: bus reset with a device answering
    queue_command(OP_RESET, 8'h00, LvLow);
    drain();

    // Shortest legal timing, all-zero and all-one bytes both ways
    fill_timing(ow_dur_t'(1));
    program_timing();
    queue_command(OP_WRITE, 8'h00, LvRand);
    queue_command(OP_WRITE, 8'hFF, LvRand);
    queue_command(OP_READ, 8'h00, LvHigh);
    queue_command(OP_READ, 8'h00, LvLow);
    queue_command(OP_RESET, 8'h00, LvHigh);
    queue_command(OP_RESET, 8'h00, LvLow);
    drain();

    // Zero registers act as one-tick phases; zero tail skips the tail
    fill_timing('0);
    program_timing();
    queue_command(OP_RESET, 8'h00, LvHigh);
    queue_command(OP_WRITE, 8'h81, LvRand);
    queue_command(OP_READ, 8'h00, LvRand);
    drain();

    fill_timing(ow_dur_t'(2));
    timing[REG_WRITE_TAIL] = '0;
    program_timing();
    queue_command(OP_WRITE, 8'h3C, LvRand);
    queue_command(OP_WRITE, 8'hC3, LvRand);
    drain();

    // Random commands over short random timings, one phase with no idling
    busy_ticks = 0;
    for (int ph = 0; busy_ticks < RandomTicks || ph < 2; ph++) begin
      random_timing();
      quiet = (ph == 1);
      repeat (5) begin
        queue_command(ow_op_e'($urandom_range(1, 3)), 8'($urandom()), LvRand);
        if ($urandom_range(7) == 0)
          repeat ($urandom_range(1, 5)) tick_q.push_back('{OP_NONE, 8'($urandom()), 1'b1});
      end
      drain();
      quiet = 1'b0;
    end

    repeat (10) @(posedge clk_i);
    if (status_q.size() != 0) begin
      errors++;
      $error("%0d results never arrived", status_q.size());
    end
    $display("covered %0d bus resets (%0d answered), %0d byte writes, %0d byte reads",
             n_cmd[OP_RESET], n_presence, n_cmd[OP_WRITE], n_cmd[OP_READ]);
    $display("%0d ticks checked, %0d commands completed, %0d mismatches",
             checked, n_done, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ow_pkg.sv
rtl/core/ow_if.sv
rtl/core/ow_cfg_regs.sv
rtl/core/ow_engine.sv
rtl/core/one_wire_bus_master.sv
tb/tb_one_wire_bus_master.sv
